// ----- rtl/core/pkhrt_pkg.sv -----
// Shared types, operation and status codes and parameter defaults for the
// process-id keyed rule table. No dependencies.
`timescale 1ns / 1ps

package pkhrt_pkg;

  localparam int BUCKETS_DEF = 64;
  localparam int WAYS_DEF    = 4;

  localparam int KEY_W   = 32;
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 9;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [KEY_W-1:0]  pid;
    logic [ADDR_W-1:0]        target_address;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ADDR_W-1:0]   found_address;
    logic [COUNT_W-1:0]  rule_count;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  key;
  } mod_req_t;

endpackage

// ----- rtl/core/pkhrt_bucket_mod.sv -----
// Bucket index unit: the key, read as unsigned, modulo the bucket count.
// Depends on pkhrt_pkg.
`timescale 1ns / 1ps

module pkhrt_bucket_mod
  import pkhrt_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mod_req_t                   req,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] bucket
);

  localparam int L = $clog2(BUCKETS);
  localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  generate
    if (IS_POW2) begin : g_pow2
      logic         done_r;
      logic [L-1:0] bucket_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= req.start;
        end
      end

      always_ff @(posedge clk) begin
        if (req.start) begin
          bucket_r <= req.key[L-1:0];
        end
      end

      assign done   = done_r;
      assign bucket = bucket_r;
    end else begin : g_recip
      // With the reciprocal rounded up, the top bits of the product are the
      // exact quotient of every 32-bit key. The remainder is below the bucket
      // count, so only the low index bits of quotient and key are kept.
      localparam int PROD_W = 2 * KEY_W + 1;
      localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (KEY_W + L)) + 64'(BUCKETS - 1)) / 64'(BUCKETS);
      localparam logic [KEY_W:0] RECIP = RECIP_FULL[KEY_W:0];
      localparam logic [L-1:0]   B_LOW = L'(BUCKETS);

      logic [PROD_W-1:0] prod;
      logic              stage_r;
      logic              done_r;
      logic [L-1:0]      key_low_r;
      logic [L-1:0]      quot_low_r;
      logic [L-1:0]      bucket_r;

      assign prod = PROD_W'(req.key) * PROD_W'(RECIP);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stage_r <= 1'b0;
          done_r  <= 1'b0;
        end else begin
          stage_r <= req.start;
          done_r  <= stage_r;
        end
      end

      always_ff @(posedge clk) begin
        if (req.start) begin
          key_low_r  <= req.key[L-1:0];
          quot_low_r <= prod[KEY_W + L +: L];
        end
        if (stage_r) begin
          bucket_r <= key_low_r - quot_low_r * B_LOW;
        end
      end

      assign done   = done_r;
      assign bucket = bucket_r;
    end
  endgenerate

endmodule

// ----- rtl/core/pid_keyed_hash_rule_table.sv -----
// Top level of the process-id keyed rule table: bucket memory, control
// sequencer and result register. Depends on pkhrt_pkg and pkhrt_bucket_mod.
`timescale 1ns / 1ps

// Exact-match table from a 32-bit process id to an IPv4 address, held as
// BUCKETS rows of WAYS entries (valid, key, address) in one synchronous
// memory with a registered read. When BUCKETS is a power of two, add, remove
// and find take these steps: the bucket index is registered at acceptance,
// the hash state issues the row read, the read state waits while the row
// settles in its register, and the execute state compares all ways and,
// once the output register is free, writes a changed row back and loads
// the result register. For any other BUCKETS the remainder unit (a
// reciprocal multiplication) registers its quotient bits before the
// remainder. Read count goes from acceptance through the done state to the
// result register. Clear sweeps the memory one row per cycle, then presents
// its result. After reset the same sweep runs before the first transaction
// is accepted. One transaction is processed at a time; a finished result
// may wait in the output register while the next transaction is taken and
// worked on.
module pid_keyed_hash_rule_table
  import pkhrt_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int ROW_W   = $clog2(BUCKETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS   = BUCKETS * WAYS;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int ENT_W   = 1 + KEY_W + ADDR_W;
  localparam int ROW_BITS = WAYS * ENT_W;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [ROW_W-1:0]  sweep_r, sweep_nxt;
  logic              sweep_resp_r, sweep_resp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;

  logic [2:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [ADDR_W-1:0] addr_r;

  logic [ROW_BITS-1:0] mem [BUCKETS];
  logic [ROW_BITS-1:0] rd_row_r;
  logic                rd_en;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [ROW_BITS-1:0] wr_row;

  mod_req_t          mod_req;
  logic              mod_done;
  logic [ROW_W-1:0]  bucket;

  logic              in_accept;
  logic              out_free;
  logic              out_load;
  out_t              res;

  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   free_vec;
  logic              hit_any;
  logic              free_any;
  logic [WAY_W-1:0]  hit_idx;
  logic [WAY_W-1:0]  free_idx;
  logic              ex_wr;
  logic [ROW_BITS-1:0] ex_row;
  logic [1:0]        ex_status;
  logic [ADDR_W-1:0] ex_found;
  logic [CNT_W-1:0]  ex_cnt;
  logic [31:0]       cnt_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Only operations that look up a key start the bucket index unit.
  assign mod_req.start = in_accept && (in_data.op == OP_ADD || in_data.op == OP_REMOVE ||
                                       in_data.op == OP_FIND);
  assign mod_req.key   = in_data.pid;

  pkhrt_bucket_mod #(
    .BUCKETS(BUCKETS)
  ) u_bucket_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .done  (mod_done),
    .bucket(bucket)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_data.op;
      key_r  <= in_data.pid;
      addr_r <= in_data.target_address;
    end
  end

  // Compare every way of the bucket row that was read.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = rd_row_r[w*ENT_W + KEY_W + ADDR_W] &&
                    (rd_row_r[w*ENT_W + ADDR_W +: KEY_W] == key_r);
      free_vec[w] = !rd_row_r[w*ENT_W + KEY_W + ADDR_W];
    end
    // Lowest way wins in both searches.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_any = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
  end

  always_comb begin
    ex_row    = rd_row_r;
    ex_wr     = 1'b0;
    ex_status = ST_OK;
    ex_found  = '0;
    ex_cnt    = cnt_r;
    case (op_r)
      OP_ADD: begin
        if (hit_any) begin
          ex_row[int'(hit_idx)*ENT_W +: ADDR_W] = addr_r;
          ex_wr = 1'b1;
        end else if (free_any) begin
          ex_row[int'(free_idx)*ENT_W +: ENT_W] = {1'b1, key_r, addr_r};
          ex_wr  = 1'b1;
          ex_cnt = cnt_r + CNT_W'(1);
        end else begin
          ex_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit_any) begin
          ex_row[int'(hit_idx)*ENT_W + KEY_W + ADDR_W] = 1'b0;
          ex_wr = 1'b1;
          if (cnt_r != '0) begin
            ex_cnt = cnt_r - CNT_W'(1);
          end
        end else begin
          ex_status = ST_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (hit_any) begin
          ex_found = rd_row_r[int'(hit_idx)*ENT_W +: ADDR_W];
        end else begin
          ex_status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_en   = (state_r == S_HASH) && mod_done;
  assign wr_en   = (state_r == S_SWEEP) || ((state_r == S_EXEC) && out_free && ex_wr);
  assign wr_addr = (state_r == S_SWEEP) ? sweep_r : bucket;
  assign wr_row  = (state_r == S_SWEEP) ? '0 : ex_row;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[bucket];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    sweep_resp_nxt = sweep_resp_r;
    cnt_nxt        = cnt_r;
    out_load       = 1'b0;
    res.status        = ST_OK;
    res.found_address = '0;
    cnt_ext           = 32'(cnt_r);
    unique case (state_r)
      S_SWEEP: begin
        sweep_nxt = sweep_r + ROW_W'(1);
        if (sweep_r == ROW_W'(BUCKETS - 1)) begin
          sweep_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = sweep_resp_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.op == OP_ADD || in_data.op == OP_REMOVE ||
              in_data.op == OP_FIND) begin
            state_nxt = S_HASH;
          end else if (in_data.op == OP_CLEAR) begin
            sweep_resp_nxt = 1'b1;
            state_nxt      = S_SWEEP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res.status        = ex_status;
        res.found_address = ex_found;
        cnt_ext           = 32'(ex_cnt);
        if (out_free) begin
          out_load  = 1'b1;
          cnt_nxt   = ex_cnt;
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res.rule_count = cnt_ext[COUNT_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_r      <= '0;
      sweep_resp_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      sweep_resp_r <= (state_r == S_DONE) ? 1'b0 : sweep_resp_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("rule count exceeds table capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("memory written while no transaction is in progress");

  a_mod_done_hash: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_HASH))
    else $error("bucket index finished outside the hash state");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result register not valid after a load");

endmodule

// ----- tb/tb_pid_keyed_hash_rule_table.sv -----
// Self-checking testbench for pid_keyed_hash_rule_table: directed rows
// followed by random traffic, checked against expected values or an in-bench
// predictor. Depends on pkhrt_pkg and the pid_keyed_hash_rule_table RTL.
`timescale 1ns / 1ps

module tb_pid_keyed_hash_rule_table;
  import pkhrt_pkg::*;

  localparam int BUCKETS     = BUCKETS_DEF;
  localparam int WAYS        = WAYS_DEF;
  localparam int SLOTS       = BUCKETS * WAYS;
  localparam int N_DIRECTED  = 25;
  localparam int N_MIXED_A   = 150;
  localparam int N_MIXED_B   = 60;
  localparam int POOL_SIZE   = 24;
  localparam int CYCLE_LIMIT = 500000;

  // Op codes the block treats as read count.
  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // Predictor state.
  bit          tbl_valid [SLOTS];
  logic [31:0] tbl_key   [SLOTS];
  logic [31:0] tbl_addr  [SLOTS];
  int          tbl_count;

  out_t        pending_results [$];
  int          fault_count = 0;
  int          cycle_count = 0;
  bit          in_burst    = 1'b0;
  bit          out_burst   = 1'b0;
  int          out_hold    = 0;
  logic [31:0] key_pool [POOL_SIZE];
  dir_row_t    dir_rows [N_DIRECTED];

  pid_keyed_hash_rule_table #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic out_t rule_table_predict(in_t req);
    logic [31:0] k;
    int          base;
    int          hit;
    out_t        res;
    k    = req.pid;
    base = int'(k % 32'(BUCKETS)) * WAYS;
    hit  = -1;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (tbl_valid[base + w] && tbl_key[base + w] == k) hit = base + w;
    end
    res.status        = ST_OK;
    res.found_address = '0;
    case (req.op)
      OP_ADD: begin
        if (hit >= 0) begin
          tbl_addr[hit] = req.target_address;
        end else begin
          res.status = ST_FULL;
          for (int w = 0; w < WAYS; w++) begin
            if (res.status == ST_FULL && !tbl_valid[base + w]) begin
              tbl_valid[base + w] = 1'b1;
              tbl_key[base + w]   = k;
              tbl_addr[base + w]  = req.target_address;
              tbl_count++;
              res.status = ST_OK;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          if (tbl_count > 0) tbl_count--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_FIND: begin
        if (hit >= 0) res.found_address = tbl_addr[hit];
        else res.status = ST_NOT_FOUND;
      end
      OP_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
        tbl_count = 0;
      end
      default: ;
    endcase
    res.rule_count = COUNT_W'(tbl_count);
    return res;
  endfunction

  function automatic dir_row_t row(logic [2:0] op, logic [31:0] pid, logic [31:0] addr,
                                   bit typed, logic [1:0] st, logic [31:0] found, int cnt);
    dir_row_t r;
    r.req.op                = op;
    r.req.pid               = pid;
    r.req.target_address    = addr;
    r.typed                 = typed;
    r.want.status           = st;
    r.want.found_address    = found;
    r.want.rule_count       = COUNT_W'(cnt);
    return r;
  endfunction

  // Mostly keys from a pool crowded into a few buckets, so that hits, misses
  // and full buckets all turn up; the rest are arbitrary 32-bit ids.
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic in_t gen_mixed_req();
    in_t req;
    int  r;
    r                  = $urandom_range(0, 99);
    req.pid            = pick_key();
    req.target_address = $urandom;
    if (r < 40) req.op = OP_ADD;
    else if (r < 62) req.op = OP_FIND;
    else if (r < 82) req.op = OP_REMOVE;
    else if (r < 85) req.op = OP_CLEAR;
    else if (r < 93) req.op = OP_COUNT;
    else req.op = 3'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
    return req;
  endfunction

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Presents one transaction after a random gap and returns at the edge that
  // accepts it. in_valid is left high so a zero gap gives back-to-back items.
  task automatic send_req(in_t req, bit typed, out_t want);
    int   gap;
    out_t predicted;
    if ($urandom_range(0, 29) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = rule_table_predict(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Result side: checks each accepted transaction and holds off the next one
  // for a random number of cycles while it is on offer.
  always @(posedge clk) begin : result_monitor
    out_t got;
    out_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          note_fault($sformatf("result with nothing outstanding: status %0d addr %h count %0d",
                               got.status, got.found_address, got.rule_count));
        end else begin
          exp_res = pending_results.pop_front();
          if (got.status !== exp_res.status || got.found_address !== exp_res.found_address ||
              got.rule_count !== exp_res.rule_count)
            note_fault($sformatf({"mismatch: expected status %0d addr %h count %0d, ",
                                  "got status %0d addr %h count %0d"},
                                 exp_res.status, exp_res.found_address, exp_res.rule_count,
                                 got.status, got.found_address, got.rule_count));
        end
        if ($urandom_range(0, 29) == 0) out_burst = ~out_burst;
        out_hold = out_burst ? 0 : $urandom_range(0, 14);
      end else if (out_valid === 1'b1 && out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pid_keyed_hash_rule_table test failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_t         req;
    logic [31:0] k;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_valid[s] = 1'b0;
      tbl_key[s]   = '0;
      tbl_addr[s]  = '0;
    end
    tbl_count = 0;
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = (32'($urandom) & ~32'(BUCKETS - 1)) | 32'($urandom_range(0, 5));

    // Bucket 0 is filled with 0, 0x80000000, 64 and 0xFFFFFFC0, then a fifth
    // id is refused; ids -1 and 0x7FFFFFFF both land in the top bucket.
    dir_rows = '{
      row(OP_COUNT,    32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,        32'h0,          0),
      row(OP_FIND,     32'h0000_0000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 32'h0,          0),
      row(OP_REMOVE,   32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 32'h0,          0),
      row(OP_ADD,      32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0,          1),
      row(OP_ADD,      32'h8000_0000, 32'h0000_0000, 1'b1, ST_OK,        32'h0,          2),
      row(OP_ADD,      32'h0000_0040, 32'hC0A8_0001, 1'b1, ST_OK,        32'h0,          3),
      row(OP_ADD,      32'hFFFF_FFC0, 32'h0A00_0001, 1'b1, ST_OK,        32'h0,          4),
      row(OP_ADD,      32'h0000_0080, 32'h0102_0304, 1'b1, ST_FULL,      32'h0,          4),
      row(OP_FIND,     32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,        32'hFFFF_FFFF,  4),
      row(OP_FIND,     32'h8000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0,          4),
      row(OP_ADD,      32'h0000_0040, 32'h1234_5678, 1'b1, ST_OK,        32'h0,          4),
      row(OP_FIND,     32'h0000_0040, 32'h0000_0000, 1'b1, ST_OK,        32'h1234_5678,  4),
      row(OP_ADD,      32'hFFFF_FFFF, 32'h7F00_0001, 1'b1, ST_OK,        32'h0,          5),
      row(OP_ADD,      32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b1, ST_OK,        32'h0,          6),
      row(OP_FIND,     32'h7FFF_FFFF, 32'h5555_5555, 1'b1, ST_OK,        32'hAAAA_AAAA,  6),
      row(OP_REMOVE,   32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,        32'h0,          5),
      row(OP_FIND,     32'h0000_0000, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 32'h0,          5),
      row(OP_ADD,      32'h0000_0080, 32'h5555_5555, 1'b0, ST_OK,        32'h0,          0),
      row(OP_UNUSED_5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0,          6),
      row(OP_UNUSED_6, 32'h8000_0000, 32'h0000_0000, 1'b1, ST_OK,        32'h0,          6),
      row(OP_UNUSED_7, 32'h0000_0080, 32'h1234_5678, 1'b1, ST_OK,        32'h0,          6),
      row(OP_COUNT,    32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, ST_OK,        32'h0,          6),
      row(OP_CLEAR,    32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, ST_OK,        32'h0,          0),
      row(OP_FIND,     32'h0000_0080, 32'h0000_0000, 1'b0, ST_OK,        32'h0,          0),
      row(OP_ADD,      32'h0000_0080, 32'h0000_0001, 1'b0, ST_OK,        32'h0,          0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < N_MIXED_A; i++) send_req(gen_mixed_req(), 1'b0, '0);

    // Fill every way of every bucket so the count reaches its top value.
    // Distinct ids per bucket come from the way number above the bucket bits;
    // the upper bits are random.
    req.op = OP_CLEAR;
    req.pid = $urandom;
    req.target_address = $urandom;
    send_req(req, 1'b0, '0);
    for (int w = 0; w < WAYS; w++) begin
      for (int b = 0; b < BUCKETS; b++) begin
        k = 32'(b + BUCKETS * w) + (32'($urandom) & ~32'(SLOTS - 1));
        req.op = OP_ADD;
        req.pid = k;
        req.target_address = $urandom;
        send_req(req, 1'b0, '0);
      end
    end
    for (int i = 0; i < 4; i++) begin
      req.op = OP_ADD;
      req.pid = $urandom;
      req.target_address = $urandom;
      send_req(req, 1'b0, '0);
    end
    req.op = OP_COUNT;
    send_req(req, 1'b0, '0);

    for (int i = 0; i < N_MIXED_B; i++) send_req(gen_mixed_req(), 1'b0, '0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (BUCKETS + 20) @(posedge clk);
    if (fault_count == 0) begin
      $display("pid_keyed_hash_rule_table test passed");
    end else begin
      $display("pid_keyed_hash_rule_table test failed");
    end
    $finish;
  end

endmodule
